// File: design/ttq_pkg.sv
// Package for the touch transition queue: event and control types, request codes and sizes.
`default_nettype none

package ttq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PEND_W      = 4;
  localparam int LOST_W      = 16;
  localparam int COORD_W     = 16;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      pressed;
  } ttq_event_t;

  typedef struct packed {
    logic load;
    logic shift;
  } ttq_cell_ctl_t;

endpackage

`default_nettype wire

// File: design/touch_transition_queue.sv
// Top level of the touch transition queue: request decode, held event, counters and cell row.
`default_nettype none

// Each accepted item is handled combinationally and its result appears in the output
// register on the next edge, so an item can be accepted every cycle while the result side
// keeps up; the input stalls only while a finished result waits and out_stall is high.
// Queued events live in a row of cells with the oldest in the first cell: a take moves
// every cell one place towards the head, and a transition is written into the cell just
// past the last occupied one. A clear resets the count, held event and lost count with no sweep of the cells.
module touch_transition_queue
  import ttq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic signed [COORD_W-1:0] in_sample_x,
  input  wire logic signed [COORD_W-1:0] in_sample_y,
  input  wire logic                      in_sample_pressed,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      out_event_x,
  output logic signed [COORD_W-1:0]      out_event_y,
  output logic                           out_event_pressed,
  output logic [PEND_W-1:0]              out_pending_count,
  output logic [LOST_W-1:0]              out_lost_count
);

  ttq_event_t          held_r, held_nxt;
  logic                last_pressed_r, last_pressed_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LOST_W-1:0]   lost_r, lost_nxt;
  logic                out_valid_r;
  ttq_event_t          out_event_r;
  logic [PEND_W-1:0]   out_pend_r;
  logic [LOST_W-1:0]   out_lost_r;

  logic                in_fire;
  req_t                req;
  logic                push_en;
  logic                pop_en;
  ttq_event_t          push_event;

  ttq_event_t          cell_data [QUEUE_DEPTH];
  ttq_cell_ctl_t       cell_ctl  [QUEUE_DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign req      = req_t'(in_req_type);

  always_comb begin
    held_nxt         = held_r;
    last_pressed_nxt = last_pressed_r;
    cnt_nxt          = cnt_r;
    lost_nxt         = lost_r;
    push_en          = 1'b0;
    pop_en           = 1'b0;
    push_event       = held_r;
    case (req)
      REQ_SAMPLE: begin
        if (in_sample_pressed) begin
          held_nxt.x = in_sample_x;
          held_nxt.y = in_sample_y;
        end
        if (in_sample_pressed != last_pressed_r) begin
          last_pressed_nxt = in_sample_pressed;
          // A press queues its own position, a release the last held one.
          push_event.pressed = in_sample_pressed;
          if (in_sample_pressed) begin
            push_event.x = in_sample_x;
            push_event.y = in_sample_y;
          end
          if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            lost_nxt = lost_r + LOST_W'(1);
          end else begin
            push_en = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      REQ_TAKE: begin
        if (cnt_r != '0) begin
          pop_en   = 1'b1;
          held_nxt = cell_data[0];
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        held_nxt         = '0;
        last_pressed_nxt = 1'b0;
        cnt_nxt          = '0;
        lost_nxt         = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ttq_event_t next_event;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_event = cell_data[i];
    end else begin : g_mid
      assign next_event = cell_data[i+1];
    end
    assign cell_ctl[i].shift = in_fire & pop_en;
    assign cell_ctl[i].load  = in_fire & push_en & (cnt_r == CNT_W'(i));
    ttq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .push_event (push_event),
      .next_event (next_event),
      .event_out  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r         <= '0;
      last_pressed_r <= 1'b0;
      cnt_r          <= '0;
      lost_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        held_r         <= held_nxt;
        last_pressed_r <= last_pressed_nxt;
        cnt_r          <= cnt_nxt;
        lost_r         <= lost_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_r <= held_nxt;
      out_pend_r  <= PEND_W'(cnt_nxt);
      out_lost_r  <= lost_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_x       = out_event_r.x;
  assign out_event_y       = out_event_r.y;
  assign out_event_pressed = out_event_r.pressed;
  assign out_pending_count = out_pend_r;
  assign out_lost_count    = out_lost_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond its depth");

  a_lost_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && req == REQ_SAMPLE && cnt_r != CNT_W'(QUEUE_DEPTH) |=> lost_r == $past(lost_r))
    else $error("lost count moved while the queue had room");

  a_take_pops : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && req == REQ_TAKE && cnt_r != '0 |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("take on a non-empty queue did not remove one item");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && out_lost_r == lost_r)
    else $error("result register does not match the lost count");

endmodule

`default_nettype wire

// File: design/ttq_cell.sv
// One storage cell of the queue: loads a pushed event or takes its neighbour's on a pop.
`default_nettype none

module ttq_cell
  import ttq_pkg::*;
(
  input  wire logic          clk,
  input  wire ttq_cell_ctl_t ctl,
  input  wire ttq_event_t    push_event,
  input  wire ttq_event_t    next_event,
  output ttq_event_t         event_out
);

  ttq_event_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= next_event;
    end else if (ctl.load) begin
      data_r <= push_event;
    end
  end

  assign event_out = data_r;

endmodule

`default_nettype wire

// File: test/ttq_report_checker.sv
`timescale 1ns / 1ps
// Checker for the touch transition queue: watches both channels, predicts each report and compares.
module ttq_report_checker
  import ttq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic signed [COORD_W-1:0] in_sample_x,
  input  wire logic signed [COORD_W-1:0] in_sample_y,
  input  wire logic                      in_sample_pressed,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic signed [COORD_W-1:0] out_event_x,
  input  wire logic signed [COORD_W-1:0] out_event_y,
  input  wire logic                      out_event_pressed,
  input  wire logic [PEND_W-1:0]         out_pending_count,
  input  wire logic [LOST_W-1:0]         out_lost_count,
  output int                             mismatches,
  output int                             reports_owed
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      pressed;
    logic [PEND_W-1:0]         pending;
    logic [LOST_W-1:0]         lost;
  } touch_report_t;

  // Own copy of the queue state, kept as a ring of slots.
  ttq_event_t        slot_events [QUEUE_DEPTH];
  int unsigned       oldest_slot;
  int unsigned       queued_total;
  logic [LOST_W-1:0] dropped_transitions;
  ttq_event_t        held_event;
  logic              finger_was_down;

  touch_report_t expected_reports[$];

  initial begin
    mismatches   = 0;
    reports_owed = 0;
  end

  function automatic void clear_touch_state();
    oldest_slot         = 0;
    queued_total        = 0;
    dropped_transitions = '0;
    held_event          = '0;
    finger_was_down     = 1'b0;
  endfunction

  function automatic void queue_transition(ttq_event_t ev);
    if (queued_total >= QUEUE_DEPTH) begin
      dropped_transitions = dropped_transitions + 1'b1;
    end else begin
      slot_events[(oldest_slot + queued_total) % QUEUE_DEPTH] = ev;
      queued_total++;
    end
  endfunction

  function automatic touch_report_t predict_touch_report(logic [1:0] req,
                                                         logic signed [COORD_W-1:0] sx,
                                                         logic signed [COORD_W-1:0] sy,
                                                         logic down);
    ttq_event_t    ev;
    touch_report_t rep;
    case (req)
      REQ_SAMPLE: begin
        if (down == finger_was_down) begin
          // A move while the finger stays down only refreshes the held position.
          if (down) begin
            held_event.x = sx;
            held_event.y = sy;
          end
        end else begin
          finger_was_down = down;
          if (down) begin
            ev.x       = sx;
            ev.y       = sy;
            ev.pressed = 1'b1;
            queue_transition(ev);
            held_event.x = sx;
            held_event.y = sy;
          end else begin
            // A release reports the last held position, not the chip's coordinates.
            ev.x       = held_event.x;
            ev.y       = held_event.y;
            ev.pressed = 1'b0;
            queue_transition(ev);
          end
        end
      end
      REQ_TAKE: begin
        if (queued_total != 0) begin
          held_event   = slot_events[oldest_slot];
          oldest_slot  = (oldest_slot + 1) % QUEUE_DEPTH;
          queued_total--;
        end
      end
      REQ_CLEAR: clear_touch_state();
      default: ;
    endcase
    rep.x       = held_event.x;
    rep.y       = held_event.y;
    rep.pressed = held_event.pressed;
    rep.pending = PEND_W'(queued_total);
    rep.lost    = dropped_transitions;
    return rep;
  endfunction

  function automatic void compare_field(string field, logic [LOST_W-1:0] want,
                                        logic [LOST_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    touch_report_t want;
    if (!rst_n) begin
      clear_touch_state();
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_touch_report(in_req_type, in_sample_x,
                                                        in_sample_y, in_sample_pressed));
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report with none expected, got x %0h y %0h pressed %0b",
                   $time, out_event_x, out_event_y, out_event_pressed);
        end else begin
          want = expected_reports.pop_front();
          compare_field("event_x", want.x, out_event_x);
          compare_field("event_y", want.y, out_event_y);
          compare_field("event_pressed", LOST_W'(want.pressed), LOST_W'(out_event_pressed));
          compare_field("pending_count", LOST_W'(want.pending), LOST_W'(out_pending_count));
          compare_field("lost_count", want.lost, out_lost_count);
        end
      end
    end
    reports_owed = expected_reports.size();
  end

endmodule

// File: test/touch_transition_queue_test.sv
`timescale 1ns / 1ps
// Top of the touch transition queue testbench: clock, reset, item stimulus, result sink and verdict.
module touch_transition_queue_test
  import ttq_pkg::*;
();

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_req_type;
  logic signed [COORD_W-1:0] in_sample_x;
  logic signed [COORD_W-1:0] in_sample_y;
  logic                      in_sample_pressed;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_event_x;
  logic signed [COORD_W-1:0] out_event_y;
  logic                      out_event_pressed;
  logic [PEND_W-1:0]         out_pending_count;
  logic [LOST_W-1:0]         out_lost_count;

  int mismatches;
  int reports_owed;
  int cycle_count;
  bit sender_steady;
  bit hold_off_wanted;
  logic finger_down;

  touch_transition_queue u_top (.*);

  ttq_report_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, one quiet window, and a long hold-off on request.
  initial begin : result_sink
    int hold_left;
    int sink_cycles;
    hold_left   = 0;
    sink_cycles = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if (hold_off_wanted && hold_left == 0) begin
        hold_off_wanted = 1'b0;
        hold_left       = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_cycles > 1500 && sink_cycles < 3500) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 26);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  task automatic offer_item(input logic [1:0] req, input logic signed [COORD_W-1:0] sx,
                            input logic signed [COORD_W-1:0] sy, input logic down);
    while (!sender_steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_sample_x       <= sx;
    in_sample_y       <= sy;
    in_sample_pressed <= down;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A chip sample that also tracks where the finger is.
  task automatic offer_sample(input logic down);
    finger_down = down;
    offer_item(REQ_SAMPLE, random_coord(), random_coord(), down);
  endtask

  task automatic offer_noise(input logic [1:0] req);
    offer_item(req, random_coord(), random_coord(), 1'($urandom()));
  endtask

  initial begin : stimulus
    int take_pct [7];
    int r;
    take_pct = '{5, 50, 20, 70, 2, 35, 15};
    sender_steady     = 1'b0;
    hold_off_wanted   = 1'b0;
    finger_down       = 1'b0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_SAMPLE;
    in_sample_x       <= '0;
    in_sample_y       <= '0;
    in_sample_pressed <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty takes, the unused request, extreme coordinates, a full queue.
    offer_item(REQ_TAKE, '1, '1, 1'b1);
    offer_item(REQ_UNUSED, 16'sh7fff, 16'sh8000, 1'b1);
    offer_item(REQ_SAMPLE, 16'sh8000, 16'sh7fff, 1'b0);
    offer_item(REQ_SAMPLE, 16'sh7fff, 16'sh8000, 1'b1);
    offer_item(REQ_SAMPLE, 16'sh8000, 16'sh7fff, 1'b1);
    offer_item(REQ_SAMPLE, 16'sh1234, 16'sh5678, 1'b0);
    offer_item(REQ_TAKE, '0, '0, 1'b0);
    offer_item(REQ_TAKE, '1, '1, 1'b1);
    offer_item(REQ_TAKE, '0, '0, 1'b0);
    // Ten transitions into an empty queue: the last two are dropped.
    for (int i = 0; i < 10; i++) offer_sample(~i[0]);
    offer_item(REQ_TAKE, '1, '1, 1'b1);
    offer_noise(REQ_CLEAR);
    finger_down = 1'b0;
    offer_item(REQ_TAKE, '0, '0, 1'b0);

    // Keep pushing transitions into a full queue so that the lost counter climbs.
    for (int i = 0; i < QUEUE_DEPTH + 20; i++) offer_sample(~finger_down);
    for (int i = 0; i <= QUEUE_DEPTH; i++) offer_noise(REQ_TAKE);
    offer_noise(REQ_CLEAR);
    finger_down = 1'b0;

    // Random: mostly press, move and release runs, with takes at varying rates.
    for (int phase = 0; phase < 7; phase++) begin
      sender_steady = (phase == 3);
      if (phase == 1) hold_off_wanted = 1'b1;
      for (int i = 0; i < 250; i++) begin
        r = $urandom_range(99);
        if (r < 2) begin
          offer_noise(REQ_CLEAR);
          finger_down = 1'b0;
        end else if (r < 4) begin
          offer_noise(REQ_UNUSED);
        end else if (r < 4 + take_pct[phase]) begin
          offer_noise(REQ_TAKE);
        end else if ($urandom_range(9) == 0) begin
          offer_sample(1'($urandom()));
        end else if ($urandom_range(99) < 25) begin
          offer_sample(~finger_down);
        end else begin
          offer_sample(finger_down);
        end
      end
    end
    sender_steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
